>>> hdl/lrfc_pkg.sv
// Shared types and constants for the LIN response frame checker.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package lrfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ID_W     = 6;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned DATA_W   = 64;
    localparam int unsigned DATA_BYTES = DATA_W / BYTE_W;

    localparam logic [BYTE_W-1:0]  SYNC_VALUE = 8'h55;
    localparam logic [COUNT_W-1:0] FRAME_LEN  = 4'd11;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd12;
    localparam logic [COUNT_W-1:0] COUNT_NONE = 4'd2;   // this many or fewer: no response
    localparam logic [COUNT_W-1:0] POS_ID     = 4'd1;
    localparam logic [COUNT_W-1:0] POS_DATA0  = 4'd2;
    localparam logic [COUNT_W-1:0] POS_DATA7  = 4'd9;
    localparam logic [COUNT_W-1:0] POS_CSUM   = 4'd10;

    typedef enum logic [2:0] {
        ST_NONE       = 3'd0,
        ST_UNEXPECTED = 3'd1,
        ST_CSUM_ERR   = 3'd2,
        ST_CHANGED    = 3'd3,
        ST_UNCHANGED  = 3'd4
    } status_t;

    // Collected state of the current response window
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [BYTE_W-1:0]  sum;
        logic               sync;
        logic [ID_W-1:0]    id;
        logic [DATA_W-1:0]  data;
        logic [BYTE_W-1:0]  csum;
    } window_t;

endpackage

`default_nettype wire

>>> hdl/lrfc_window.sv
// Response window collector: byte count, enhanced checksum, sync, id, data and checksum bytes.
// Depends on lrfc_pkg.
`default_nettype none

module lrfc_window (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        byte_en,
    input  wire logic                        clear,
    input  wire logic [lrfc_pkg::BYTE_W-1:0] rx_byte,
    output lrfc_pkg::window_t                win
);

    lrfc_pkg::window_t win_reg;
    lrfc_pkg::window_t win_next;
    logic [lrfc_pkg::BYTE_W:0] sum_wide;

    assign win = win_reg;

    always_comb
    begin
        win_next = win_reg;
        sum_wide = {1'b0, win_reg.sum} + {1'b0, rx_byte};
        if (clear)
        begin
            win_next = '0;
        end
        else if (byte_en)
        begin
            if (win_reg.count == '0)
            begin
                win_next.sync = (rx_byte == lrfc_pkg::SYNC_VALUE);
            end
            if (win_reg.count == lrfc_pkg::POS_ID)
            begin
                win_next.id = rx_byte[lrfc_pkg::ID_W-1:0];
            end
            // end-around carry add over bytes 1 to 9
            if (win_reg.count >= lrfc_pkg::POS_ID && win_reg.count <= lrfc_pkg::POS_DATA7)
            begin
                win_next.sum = sum_wide[lrfc_pkg::BYTE_W-1:0]
                             + {{(lrfc_pkg::BYTE_W-1){1'b0}}, sum_wide[lrfc_pkg::BYTE_W]};
            end
            for (int k = 0; k < lrfc_pkg::DATA_BYTES; k++)
            begin
                if (win_reg.count == lrfc_pkg::POS_DATA0 + lrfc_pkg::COUNT_W'(k))
                begin
                    win_next.data[(lrfc_pkg::DATA_BYTES-1-k)*lrfc_pkg::BYTE_W +: lrfc_pkg::BYTE_W]
                        = rx_byte;
                end
            end
            if (win_reg.count == lrfc_pkg::POS_CSUM)
            begin
                win_next.csum = rx_byte;
            end
            if (win_reg.count < lrfc_pkg::COUNT_MAX)
            begin
                win_next.count = win_reg.count + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else
        begin
            win_reg <= win_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lrfc_eval.sv
// Frame judgment at window end and the stored reference frame.
// Depends on lrfc_pkg.
`default_nettype none

module lrfc_eval (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        eval_en,
    input  wire lrfc_pkg::window_t           win,
    input  wire logic [lrfc_pkg::ID_W-1:0]   expected_id,
    input  wire logic                        grab_ref,
    output lrfc_pkg::status_t                status,
    output logic                             ref_updated
);

    logic [lrfc_pkg::DATA_W-1:0] ref_data_reg;
    logic [lrfc_pkg::DATA_W-1:0] ref_data_next;
    logic                        ref_valid_reg;
    logic                        ref_valid_next;
    logic                        good;

    always_comb
    begin
        good = 1'b0;
        if (win.count <= lrfc_pkg::COUNT_NONE)
        begin
            status = lrfc_pkg::ST_NONE;
        end
        else if (win.count != lrfc_pkg::FRAME_LEN || !win.sync || win.id != expected_id)
        begin
            status = lrfc_pkg::ST_UNEXPECTED;
        end
        else if (~win.sum != win.csum)
        begin
            status = lrfc_pkg::ST_CSUM_ERR;
        end
        else
        begin
            good = 1'b1;
            if (ref_valid_reg && win.data == ref_data_reg)
            begin
                status = lrfc_pkg::ST_UNCHANGED;
            end
            else
            begin
                status = lrfc_pkg::ST_CHANGED;
            end
        end
        ref_updated    = grab_ref && good;
        ref_data_next  = ref_data_reg;
        ref_valid_next = ref_valid_reg;
        if (eval_en && ref_updated)
        begin
            ref_data_next  = win.data;
            ref_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_data_reg  <= '0;
            ref_valid_reg <= 1'b0;
        end
        else
        begin
            ref_data_reg  <= ref_data_next;
            ref_valid_reg <= ref_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/lin_response_frame_checker_unit.sv
// LIN response frame checker, top level.
// A window-end request is held in the input register, then its result is loaded into the
// result register once that slot is free; bytes give no result.
// Throughput: one request per cycle, but a window end waits while the result slot is full.
// Reset (rst_n low, asynchronous): window state, reference and both valid flags clear.
// Depends on lrfc_pkg, lrfc_window and lrfc_eval.
`default_nettype none

module lin_response_frame_checker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // rx_byte[7:0], expected_id[13:8], grab_ref[14], 0
    input  wire logic        s_tuser,   // kind: 0 byte, 1 window end
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata    // frame_status[2:0], frame_data[66:3],
                                        // ref_updated[67], 0
);

    // Input register: holds one request until the datapath takes it
    logic                            in_valid_reg;
    logic                            in_valid_next;
    logic                            in_kind_reg;
    logic [lrfc_pkg::BYTE_W-1:0]     in_byte_reg;
    logic [lrfc_pkg::ID_W-1:0]       in_id_reg;
    logic                            in_grab_reg;

    // Result register
    logic                            out_valid_reg;
    logic                            out_valid_next;
    lrfc_pkg::status_t               out_status_reg;
    logic [lrfc_pkg::DATA_W-1:0]     out_data_reg;
    logic                            out_updated_reg;

    logic                            out_free;
    logic                            fire;
    logic                            byte_en;
    logic                            eval_en;
    lrfc_pkg::window_t               win;
    lrfc_pkg::status_t               status;
    logic                            ref_updated;

    // A byte request never needs the result slot; a window end needs it free
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!in_kind_reg || out_free);
    assign byte_en  = fire && !in_kind_reg;
    assign eval_en  = fire && in_kind_reg;
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (eval_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on acceptance / on evaluation only
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_id_reg   <= s_tdata[13:8];
            in_grab_reg <= s_tdata[14];
        end
        if (eval_en)
        begin
            out_status_reg  <= status;
            out_data_reg    <= win.data;
            out_updated_reg <= ref_updated;
        end
    end

    lrfc_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_en),
        .clear   (eval_en),
        .rx_byte (in_byte_reg),
        .win     (win)
    );

    lrfc_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .eval_en     (eval_en),
        .win         (win),
        .expected_id (in_id_reg),
        .grab_ref    (in_grab_reg),
        .status      (status),
        .ref_updated (ref_updated)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_updated_reg, out_data_reg, out_status_reg};

`ifndef SYNTHESIS
    // A replaced reference only ever comes from a frame with a good checksum
    a_update_good: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_updated_reg |->
            (out_status_reg == lrfc_pkg::ST_CHANGED ||
             out_status_reg == lrfc_pkg::ST_UNCHANGED))
        else $error("ref_updated on a frame that is not good");

    // Window clears after every evaluation
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        eval_en |=> (win.count == '0 && win.sum == '0 && win.data == '0))
        else $error("window not cleared after evaluation");

    // Byte count never passes its saturation value
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        win.count <= lrfc_pkg::COUNT_MAX)
        else $error("byte count beyond saturation");

    // Evaluation only when the result slot is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        eval_en |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before it was taken");

    // Input side stalls only while a request waits in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && in_kind_reg && out_valid_reg))
        else $error("input stalled without a waiting window end");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for lin_response_frame_checker_unit: LIN response windows go in
// as byte and window-end requests, verdicts are predicted in-bench and compared per field.
// Depends on lrfc_pkg and the RTL of the block only.

module tb_top;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int DIRECTED_REQS = 25;
    localparam int RANDOM_REQS   = 1425;
    localparam int HOLD_AT_REQ   = 600;     // start the long receiver hold-off here
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 12;      // margin for the last result to drain
    localparam int LIMIT_CYCLES  = 200000;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_CADENCE,
        READY_SPARSE
    } ready_mode_t;

    typedef struct {
        logic       kind;
        logic [7:0] rx;
        logic [5:0] exp_id;
        logic       grab;
    } lin_req_t;

    typedef struct {
        lrfc_pkg::status_t status;
        logic [63:0]       data;
        logic              updated;
    } frame_verdict_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'h0000;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;

    lin_req_t       lin_requests[$];
    frame_verdict_t frame_verdicts[$];

    // Mirror of the block's window and reference state
    logic [3:0]  win_count;
    logic [7:0]  win_sum;
    logic        win_sync;
    logic [5:0]  win_id;
    logic [63:0] win_data;
    logic [7:0]  win_csum;
    logic [63:0] ref_data;
    logic        ref_valid;

    int total_reqs  = 0;
    int reqs_taken  = 0;
    int mismatches  = 0;
    int cycle_count = 0;
    logic req_fire  = 1'b0;

    lin_response_frame_checker_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // LIN enhanced checksum step: 8-bit add with end-around carry
    function automatic logic [7:0] carry_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[8])
            s = s - 9'd255;
        return s[7:0];
    endfunction

    function automatic void clear_window();
        win_count = '0;
        win_sum   = '0;
        win_sync  = 1'b0;
        win_id    = '0;
        win_data  = '0;
        win_csum  = '0;
    endfunction

    // Advance the mirrored state by one accepted request; queue a verdict at window end
    function automatic void judge_lin_request(input logic kind, input logic [7:0] rx,
                                              input logic [5:0] exp_id, input logic grab);
        frame_verdict_t v;
        logic           good;
        int unsigned    slot;
        good = 1'b0;
        if (kind == KIND_BYTE) begin
            if (win_count == 4'd0)
                win_sync = (rx == lrfc_pkg::SYNC_VALUE);
            if (win_count == lrfc_pkg::POS_ID)
                win_id = rx[5:0];
            if (win_count >= lrfc_pkg::POS_ID && win_count <= lrfc_pkg::POS_DATA7)
                win_sum = carry_add(win_sum, rx);
            if (win_count >= lrfc_pkg::POS_DATA0 && win_count <= lrfc_pkg::POS_DATA7) begin
                slot = 8 * (lrfc_pkg::POS_DATA7 - win_count);
                win_data[slot +: 8] = rx;
            end
            if (win_count == lrfc_pkg::POS_CSUM)
                win_csum = rx;
            if (win_count < lrfc_pkg::COUNT_MAX)
                win_count = win_count + 4'd1;
            return;
        end
        if (win_count <= lrfc_pkg::COUNT_NONE)
            v.status = lrfc_pkg::ST_NONE;
        else if (win_count != lrfc_pkg::FRAME_LEN || !win_sync || win_id != exp_id)
            v.status = lrfc_pkg::ST_UNEXPECTED;
        else if (~win_sum != win_csum)
            v.status = lrfc_pkg::ST_CSUM_ERR;
        else begin
            good = 1'b1;
            // compare against the old reference, before any grab
            v.status = (ref_valid && win_data == ref_data) ? lrfc_pkg::ST_UNCHANGED
                                                           : lrfc_pkg::ST_CHANGED;
        end
        v.data    = win_data;
        v.updated = grab && good;
        if (v.updated) begin
            ref_data  = win_data;
            ref_valid = 1'b1;
        end
        frame_verdicts.push_back(v);
        clear_window();
    endfunction

    // Stimulus helpers: unused fields of each request carry random values
    task automatic push_byte(input logic [7:0] rx);
        lin_req_t r;
        r.kind   = KIND_BYTE;
        r.rx     = rx;
        r.exp_id = 6'($urandom);
        r.grab   = 1'($urandom);
        lin_requests.push_back(r);
    endtask

    task automatic push_end(input logic [5:0] exp_id, input logic grab);
        lin_req_t r;
        r.kind   = KIND_END;
        r.rx     = 8'($urandom);
        r.exp_id = exp_id;
        r.grab   = grab;
        lin_requests.push_back(r);
    endtask

    // Build a response window and send its first nbytes bytes; csum_flip spoils the checksum
    task automatic queue_window(input logic [7:0] sync_b, input logic [7:0] id_b,
                                input logic [63:0] payload, input logic [7:0] csum_flip,
                                input int nbytes);
        logic [7:0] wbytes [0:15];
        logic [7:0] sum;
        sum       = 8'h00;
        wbytes[0] = sync_b;
        wbytes[1] = id_b;
        for (int i = 0; i < 8; i++)
            wbytes[2 + i] = payload[63 - 8 * i -: 8];
        for (int i = 1; i <= 9; i++)
            sum = carry_add(sum, wbytes[i]);
        wbytes[10] = ~sum ^ csum_flip;
        for (int i = 11; i < 16; i++)
            wbytes[i] = 8'($urandom);
        for (int i = 0; i < nbytes; i++)
            push_byte(wbytes[i]);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Fill the request queue, then wait for the run to drain and report
    initial
    begin
        int          pick;
        logic [5:0]  fid;
        logic [7:0]  id_b;
        logic [63:0] payload;
        logic [63:0] last_payload;
        logic        grab;

        ref_data  = '0;
        ref_valid = 1'b0;
        clear_window();
        last_payload = '0;

        // Empty window with a grab: no response, reference must stay untouched
        push_end(6'h3F, 1'b1);
        // Good frame, parity bits set, no reference yet: changed, no grab
        queue_window(lrfc_pkg::SYNC_VALUE, 8'hFF, 64'h00FF00FF_FF00FF00, 8'h00, 11);
        push_end(6'h3F, 1'b0);
        // Same data, identifier 0, grabbed: still changed, reference replaced
        queue_window(lrfc_pkg::SYNC_VALUE, 8'h00, 64'h00FF00FF_FF00FF00, 8'h00, 11);
        push_end(6'h00, 1'b1);

        // Mostly well-formed frames with random content; repeat data so that
        // unchanged verdicts come up, and mix in broken and odd-length windows
        while (lin_requests.size() < DIRECTED_REQS + RANDOM_REQS) begin
            pick = $urandom_range(0, 99);
            fid  = 6'($urandom);
            id_b = {2'($urandom_range(0, 3)), fid};
            grab = 1'($urandom);
            if ($urandom_range(0, 9) < 4)
                payload = last_payload;
            else if ($urandom_range(0, 15) == 0)
                payload = ($urandom_range(0, 1) == 1) ? '1 : '0;
            else
                payload = {$urandom, $urandom};
            if (pick < 55) begin
                queue_window(lrfc_pkg::SYNC_VALUE, id_b, payload, 8'h00, 11);
                push_end(fid, grab);
                last_payload = payload;
            end
            else if (pick < 65) begin
                queue_window(lrfc_pkg::SYNC_VALUE, id_b, payload,
                             8'($urandom_range(1, 255)), 11);
                push_end(fid, grab);
            end
            else if (pick < 72) begin
                queue_window(lrfc_pkg::SYNC_VALUE ^ 8'($urandom_range(1, 255)), id_b, payload,
                             8'h00, 11);
                push_end(fid, grab);
            end
            else if (pick < 79) begin
                queue_window(lrfc_pkg::SYNC_VALUE, id_b, payload, 8'h00, 11);
                push_end(fid ^ 6'($urandom_range(1, 63)), grab);
            end
            else if (pick < 87) begin
                queue_window(lrfc_pkg::SYNC_VALUE, id_b, payload, 8'h00,
                             ($urandom_range(0, 1) == 1) ? 12 : 10);
                push_end(fid, grab);
            end
            else if (pick < 95) begin
                queue_window(8'($urandom), id_b, payload, 8'($urandom),
                             $urandom_range(0, 15));
                push_end(6'($urandom), grab);
            end
            else begin
                // short runt or a bare window end
                queue_window(lrfc_pkg::SYNC_VALUE, id_b, payload, 8'h00,
                             $urandom_range(0, 2));
                push_end(fid, grab);
            end
        end
        total_reqs = lin_requests.size();

        @(posedge rst_n);
        while (reqs_taken < total_reqs)
            @(posedge clk);
        while (frame_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Request driver: bursts of random length separated by random gaps
    int       burst_left = 0;
    int       gap_left   = 0;
    lin_req_t next_req;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || req_fire) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end
            else if (lin_requests.size() != 0) begin
                next_req = lin_requests.pop_front();
                s_tdata  <= {1'b0, next_req.grab, next_req.exp_id, next_req.rx};
                s_tuser  <= next_req.kind;
                s_tvalid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else begin
                    burst_left = burst_left - 1;
                end
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: a stall pattern re-picked at random, plus one long hold-off
    ready_mode_t ready_mode   = READY_ALWAYS;
    int          rx_cycle     = 0;
    int          holdoff_left = 0;
    logic        holdoff_done = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            rx_cycle = rx_cycle + 1;
            if (!holdoff_done && reqs_taken >= HOLD_AT_REQ) begin
                holdoff_done = 1'b1;
                holdoff_left = HOLD_CYCLES;
            end
            if (rx_cycle % 256 == 0)
                ready_mode = ready_mode_t'($urandom_range(0, 3));
            if (holdoff_left != 0) begin
                // hold off while the sender keeps pushing, so the block backs up
                holdoff_left = holdoff_left - 1;
                m_tready <= 1'b0;
            end
            else begin
                case (ready_mode)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_RANDOM:  m_tready <= 1'($urandom_range(0, 1));
                    READY_CADENCE: m_tready <= (rx_cycle % 5 < 3);
                    default:       m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Monitor: check accepted results first, then feed accepted requests to the predictor
    frame_verdict_t want;

    always @(posedge clk)
    begin
        if (!rst_n) begin
            req_fire <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (frame_verdicts.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: result with no verdict pending, got status %0d data %h upd %b",
                             $time, m_tdata[2:0], m_tdata[66:3], m_tdata[67]);
                end
                else begin
                    want = frame_verdicts.pop_front();
                    if (m_tdata[2:0] != want.status) begin
                        mismatches = mismatches + 1;
                        $display("%0t: frame_status expected %0d got %0d",
                                 $time, want.status, m_tdata[2:0]);
                    end
                    if (m_tdata[66:3] != want.data) begin
                        mismatches = mismatches + 1;
                        $display("%0t: frame_data expected %h got %h",
                                 $time, want.data, m_tdata[66:3]);
                    end
                    if (m_tdata[67] != want.updated) begin
                        mismatches = mismatches + 1;
                        $display("%0t: ref_updated expected %b got %b",
                                 $time, want.updated, m_tdata[67]);
                    end
                end
            end
            req_fire <= s_tvalid && s_tready;
            if (s_tvalid && s_tready) begin
                judge_lin_request(s_tuser, s_tdata[7:0], s_tdata[13:8], s_tdata[14]);
                reqs_taken = reqs_taken + 1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule

>>> files.f
hdl/lrfc_pkg.sv
hdl/lrfc_window.sv
hdl/lrfc_eval.sv
hdl/lin_response_frame_checker_unit.sv
tb/sv/tb_top.sv
